// ===== src/iicc_pkg.sv =====
// Package for the illumination-invariant color converter: item types, matrix
// coefficients, fixed-point widths and the natural-log lookup table.
// No dependencies; used by illumination_invariant_color_convert.
package iicc_pkg;

  // Format controls
  localparam int OUT_FRAC_BITS       = 8;   // fraction bits of the outputs (4..12)
  localparam int LOG_TABLE_ADDR_BITS = 8;   // log table index width (4..12)

  // Item field widths
  localparam int CH_W  = 8;
  localparam int OUT_W = 17;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // First matrix: Q1.16 coefficients, channel products and sums
  localparam int B_COEF_W = 18;
  localparam int PB_W     = B_COEF_W + CH_W + 1;
  localparam int SB_W     = PB_W + 2;
  localparam int MAG_W    = 25;               // |B * ch| stays below 2^25
  localparam int MAG_FRAC = 16;
  localparam int P_W      = $clog2(MAG_W);

  // Log in Q.16, signed
  localparam int ENTRY_W = 16;
  localparam int TBL_SIZE = 1 << LOG_TABLE_ADDR_BITS;
  localparam int L_W     = 22;
  localparam int LN2_Q16 = 45426;

  // Second matrix: Q16 coefficients, products, sums and rounding
  localparam int A_COEF_W  = 22;
  localparam int PA_W      = A_COEF_W + L_W;
  localparam int SA_W      = PA_W + 2;
  localparam int RND_W     = SA_W + 1;
  localparam int RND_SHIFT = 32 - OUT_FRAC_BITS;

  localparam logic signed [B_COEF_W-1:0] MAT_B [3][3] = '{
    '{ 18'sd62031,  18'sd19313, -18'sd8608},
    '{-18'sd7728,   18'sd65077,  18'sd483},
    '{ 18'sd6049,  -18'sd3045,   18'sd65185}
  };

  localparam logic signed [A_COEF_W-1:0] MAT_A [3][3] = '{
    '{ 22'sd1774347, -22'sd1494734, -22'sd118403},
    '{-22'sd370064,  -22'sd506077,   22'sd843123},
    '{-22'sd272835,  -22'sd300117,  -22'sd299896}
  };

  typedef struct packed {
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch2;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] out0;
    logic [OUT_W-1:0] out1;
    logic [OUT_W-1:0] out2;
    logic             zero_clamped;
  } out_item_t;

  typedef logic [TBL_SIZE-1:0][ENTRY_W-1:0] ln_tbl_t;

  // Shift-subtract long division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + k / 2^T) in Q.16 via atanh series 2*sum(y^n / n), odd n, y = k/(2^(T+1)+k)
  function automatic logic [ENTRY_W-1:0] ln_entry(input int k);
    logic [63:0] den;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] w;
    logic [63:0] s;
    logic [63:0] n;
    logic [63:0] t;
    den = (64'd1 << (LOG_TABLE_ADDR_BITS + 1)) + 64'(k);
    y   = udiv64(64'(k) << 32, den);
    y2  = (y * y) >> 32;
    w   = y;
    s   = '0;
    n   = 64'd1;
    for (int it = 0; it < 64; it++) begin
      if (w != '0) begin
        s = s + udiv64(w, n);
        w = (w * y2) >> 32;
        n = n + 64'd2;
      end
    end
    t = ((s << 1) + (64'd1 << 15)) >> 16;
    return t[ENTRY_W-1:0];
  endfunction

  function automatic ln_tbl_t build_ln_table();
    ln_tbl_t tbl;
    for (int k = 0; k < TBL_SIZE; k++) begin
      tbl[k] = ln_entry(k);
    end
    return tbl;
  endfunction

  localparam ln_tbl_t LN_TABLE = build_ln_table();

endpackage

// ===== src/illumination_invariant_color_convert.sv =====
// Illumination-invariant color converter: nine-stage pipeline from pixel bytes
// to |A * ln(|B * ch|)| in unsigned fixed point. Depends on iicc_pkg.

// One pixel item enters per clock unless in_stall is raised; the
// nine register stages are two for the first matrix (products, then sum and
// magnitude), three for the log (leading-one search, normalizing shift, table
// lookup with exponent term), and four for the second matrix (products, sum,
// magnitude, rounding and saturation). Each stage holds its own valid bit and
// keeps its item while the stage after it is full and stalled, so bubbles close
// up and an item is still accepted while the output waits if a stage is empty.
// A zero magnitude after the first matrix is taken as one LSB and raises
// zero_clamped. The log table is a constant built at elaboration.
module illumination_invariant_color_convert (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iicc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iicc_pkg::out_item_t out_data
);

  localparam int NST = 9;
  localparam int LT  = iicc_pkg::LOG_TABLE_ADDR_BITS;
  localparam logic [iicc_pkg::RND_W-1:0] ROUND_BIAS =
    iicc_pkg::RND_W'(1) << (31 - iicc_pkg::OUT_FRAC_BITS);

  // Stage valid bits and per-stage load enables
  logic [NST:1] v_r;
  logic [NST:1] v_nxt;
  logic [NST:1] en;

  // Stage 1: first-matrix products
  logic signed [iicc_pkg::CH_W:0]   ch_s [3];
  logic signed [iicc_pkg::PB_W-1:0] s1_prod_nxt [3][3];
  logic signed [iicc_pkg::PB_W-1:0] s1_prod_r   [3][3];

  // Stage 2: sums, magnitudes, zero clamp
  logic signed [iicc_pkg::SB_W-1:0] s2_sum [3];
  logic [iicc_pkg::SB_W-1:0]        s2_abs [3];
  logic [iicc_pkg::MAG_W-1:0]       s2_mag_nxt [3];
  logic [iicc_pkg::MAG_W-1:0]       s2_mag_r   [3];
  logic                             s2_z_nxt;
  logic                             s2_z_r;

  // Stage 3: leading-one position
  logic [iicc_pkg::P_W-1:0]   s3_p_nxt [3];
  logic [iicc_pkg::P_W-1:0]   s3_p_r   [3];
  logic [iicc_pkg::MAG_W-1:0] s3_mag_r [3];
  logic                       s3_z_r;

  // Stage 4: normalized fraction index
  logic [iicc_pkg::MAG_W-1:0] s4_norm   [3];
  logic [LT-1:0]              s4_idx_nxt [3];
  logic [LT-1:0]              s4_idx_r   [3];
  logic [iicc_pkg::P_W-1:0]   s4_p_r     [3];
  logic                       s4_z_r;

  // Stage 5: log value
  logic signed [iicc_pkg::L_W-1:0] s5_pe    [3];
  logic signed [iicc_pkg::L_W-1:0] s5_l_nxt [3];
  logic signed [iicc_pkg::L_W-1:0] s5_l_r   [3];
  logic                            s5_z_r;

  // Stage 6: second-matrix products
  logic signed [iicc_pkg::PA_W-1:0] s6_prod_nxt [3][3];
  logic signed [iicc_pkg::PA_W-1:0] s6_prod_r   [3][3];
  logic                             s6_z_r;

  // Stage 7: second-matrix sums
  logic signed [iicc_pkg::SA_W-1:0] s7_sum_nxt [3];
  logic signed [iicc_pkg::SA_W-1:0] s7_sum_r   [3];
  logic                             s7_z_r;

  // Stage 8: magnitudes
  logic [iicc_pkg::SA_W-1:0] s8_abs_nxt [3];
  logic [iicc_pkg::SA_W-1:0] s8_abs_r   [3];
  logic                      s8_z_r;

  // Stage 9: rounding, saturation, output register
  logic [iicc_pkg::RND_W-1:0] s9_rnd [3];
  logic [iicc_pkg::RND_W-1:0] s9_q   [3];
  logic [iicc_pkg::OUT_W-1:0] s9_out [3];
  iicc_pkg::out_item_t        out_nxt;
  iicc_pkg::out_item_t        out_r;

  // Position of the highest set bit
  function automatic logic [iicc_pkg::P_W-1:0] lead_one(input logic [iicc_pkg::MAG_W-1:0] m);
    logic [iicc_pkg::P_W-1:0] p;
    p = '0;
    for (int i = 0; i < iicc_pkg::MAG_W; i++) begin
      if (m[i]) begin
        p = iicc_pkg::P_W'(i);
      end
    end
    return p;
  endfunction

  // A stage loads when empty or when the next stage takes its item
  always_comb begin
    en[NST] = !v_r[NST] || !out_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[1] = en[1] ? in_valid : v_r[1];
    for (int k = 2; k <= NST; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[NST];
  assign out_data  = out_r;

  // Stage 1 logic
  always_comb begin
    ch_s[0] = $signed({1'b0, in_data.ch0});
    ch_s[1] = $signed({1'b0, in_data.ch1});
    ch_s[2] = $signed({1'b0, in_data.ch2});
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_prod_nxt[i][j] = iicc_pkg::PB_W'(iicc_pkg::MAT_B[i][j])
                          * iicc_pkg::PB_W'(ch_s[j]);
      end
    end
  end

  // Stage 2 logic: a zero magnitude becomes one LSB
  always_comb begin
    s2_z_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s2_sum[i] = iicc_pkg::SB_W'(s1_prod_r[i][0]) + iicc_pkg::SB_W'(s1_prod_r[i][1])
                + iicc_pkg::SB_W'(s1_prod_r[i][2]);
      s2_abs[i] = s2_sum[i][iicc_pkg::SB_W-1] ? iicc_pkg::SB_W'(-s2_sum[i])
                                              : iicc_pkg::SB_W'(s2_sum[i]);
      s2_mag_nxt[i] = s2_abs[i][iicc_pkg::MAG_W-1:0];
      if (s2_mag_nxt[i] == '0) begin
        s2_mag_nxt[i] = iicc_pkg::MAG_W'(1);
        s2_z_nxt      = 1'b1;
      end
    end
  end

  // Stages 3 to 5 logic: exponent, fraction index, table lookup
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_p_nxt[i]   = lead_one(s2_mag_r[i]);
      s4_norm[i]    = s3_mag_r[i] << (iicc_pkg::P_W'(iicc_pkg::MAG_W - 1) - s3_p_r[i]);
      s4_idx_nxt[i] = s4_norm[i][iicc_pkg::MAG_W-2 -: LT];
      s5_pe[i]      = $signed(iicc_pkg::L_W'(s4_p_r[i])) - iicc_pkg::L_W'(iicc_pkg::MAG_FRAC);
      s5_l_nxt[i]   = s5_pe[i] * iicc_pkg::L_W'(iicc_pkg::LN2_Q16)
                    + $signed(iicc_pkg::L_W'(iicc_pkg::LN_TABLE[s4_idx_r[i]]));
    end
  end

  // Stages 6 to 9 logic: second matrix, magnitude, rounding, saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s6_prod_nxt[i][j] = iicc_pkg::PA_W'(iicc_pkg::MAT_A[i][j])
                          * iicc_pkg::PA_W'(s5_l_r[j]);
      end
      s7_sum_nxt[i] = iicc_pkg::SA_W'(s6_prod_r[i][0]) + iicc_pkg::SA_W'(s6_prod_r[i][1])
                    + iicc_pkg::SA_W'(s6_prod_r[i][2]);
      s8_abs_nxt[i] = s7_sum_r[i][iicc_pkg::SA_W-1] ? iicc_pkg::SA_W'(-s7_sum_r[i])
                                                    : iicc_pkg::SA_W'(s7_sum_r[i]);
      s9_rnd[i] = iicc_pkg::RND_W'(s8_abs_r[i]) + ROUND_BIAS;
      s9_q[i]   = s9_rnd[i] >> iicc_pkg::RND_SHIFT;
      s9_out[i] = (s9_q[i] > iicc_pkg::RND_W'(iicc_pkg::OUT_MAX)) ? iicc_pkg::OUT_MAX
                                                                  : s9_q[i][iicc_pkg::OUT_W-1:0];
    end
    out_nxt.out0         = s9_out[0];
    out_nxt.out1         = s9_out[1];
    out_nxt.out2         = s9_out[2];
    out_nxt.zero_clamped = s8_z_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_prod_r <= s1_prod_nxt;
    end
    if (en[2]) begin
      s2_mag_r <= s2_mag_nxt;
      s2_z_r   <= s2_z_nxt;
    end
    if (en[3]) begin
      s3_p_r   <= s3_p_nxt;
      s3_mag_r <= s2_mag_r;
      s3_z_r   <= s2_z_r;
    end
    if (en[4]) begin
      s4_idx_r <= s4_idx_nxt;
      s4_p_r   <= s3_p_r;
      s4_z_r   <= s3_z_r;
    end
    if (en[5]) begin
      s5_l_r <= s5_l_nxt;
      s5_z_r <= s4_z_r;
    end
    if (en[6]) begin
      s6_prod_r <= s6_prod_nxt;
      s6_z_r    <= s5_z_r;
    end
    if (en[7]) begin
      s7_sum_r <= s7_sum_nxt;
      s7_z_r   <= s6_z_r;
    end
    if (en[8]) begin
      s8_abs_r <= s8_abs_nxt;
      s8_z_r   <= s7_z_r;
    end
    if (en[9]) begin
      out_r <= out_nxt;
    end
  end

  // A raised zero flag means some magnitude was clamped to one LSB
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && s2_z_r |->
      (s2_mag_r[0] == iicc_pkg::MAG_W'(1)) || (s2_mag_r[1] == iicc_pkg::MAG_W'(1)) ||
      (s2_mag_r[2] == iicc_pkg::MAG_W'(1)))
    else $error("zero flag set without a clamped magnitude");

  // The exponent points at the leading one of each magnitude
  a_lead_one: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> ((s3_mag_r[0] >> s3_p_r[0]) == iicc_pkg::MAG_W'(1)) &&
               ((s3_mag_r[1] >> s3_p_r[1]) == iicc_pkg::MAG_W'(1)) &&
               ((s3_mag_r[2] >> s3_p_r[2]) == iicc_pkg::MAG_W'(1)))
    else $error("log exponent does not match leading one");

  // A blocked stage 7 keeps its item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] && !en[8] |=> v_r[7] && $stable(s7_sum_r[0]) && $stable(s7_z_r))
    else $error("stalled stage lost or changed its item");

  // Input is never stalled while the output side is empty
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NST] |-> !in_stall)
    else $error("input stalled with room in the pipeline");

endmodule
